@@ rtl/core/temporal_correlation_prefetcher_defines.svh @@
// ----------------------------------------------------------------------------
// temporal correlation prefetcher assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef TEMPORAL_CORRELATION_PREFETCHER_DEFINES_SVH
`define TEMPORAL_CORRELATION_PREFETCHER_DEFINES_SVH

// consequent must hold on the cycle after the antecedent
`define TCP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tcp check failed");

// consequent must hold in the same cycle as the antecedent
`define TCP_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tcp check failed");

`endif

@@ rtl/core/tcp_pkg.sv @@
// ----------------------------------------------------------------------------
// tcp_pkg
// fixed field widths and shared types of the temporal correlation prefetcher
// ----------------------------------------------------------------------------
`default_nettype none

package tcp_pkg;

	localparam int ADDR_W   = 48;
	localparam int DEGREE_W = 5;

	// result flags of the shared match unit
	typedef struct packed {
		logic hit;
		logic succ_nz;
	} tcp_match_t;

endpackage

`default_nettype wire

@@ rtl/core/tcp_ram.sv @@
// ----------------------------------------------------------------------------
// tcp_ram
// simple dual-port table memory, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8,
	parameter int AW    = 8
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/tcp_match.sv @@
// ----------------------------------------------------------------------------
// tcp_match
// shared key compare: full-key match of a table entry and successor select
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_match
	import tcp_pkg::*;
(
	input  wire logic              valid,
	input  wire logic [ADDR_W-1:0] probe,
	input  wire logic [ADDR_W-1:0] key,
	input  wire logic [ADDR_W-1:0] data,
	output tcp_match_t             flags,
	output logic      [ADDR_W-1:0] succ
);

	logic hit;

	assign hit           = valid && (key == probe);
	assign succ          = hit ? data : '0;
	assign flags.hit     = hit;
	assign flags.succ_nz = hit && (data != '0);

endmodule

`default_nettype wire

@@ rtl/core/temporal_correlation_prefetcher.sv @@
// a load reads the training table; S_TCHK refreshes the pc entry and records the correlation
// on a pc hit; S_LOOK and S_CHK walk the chain, a prefetch leaving S_CHK once its successor is
// known, the last in S_FIN once the degree is reached; in_stall is held until the walk ends
// and out_stall holds the walk; the corr read port and the one shared key comparator set its rate
// reset: asynchronous, active low; then a clearing pass over max(TRAIN_ENTRIES, CORR_ENTRIES)
// table indices (4096 by default) sweeps both tables under in_stall; degree writes are taken throughout
// ----------------------------------------------------------------------------
// temporal_correlation_prefetcher
// per-pc training, block-to-block correlation recording and chained prefetch
// ----------------------------------------------------------------------------
`default_nettype none

module temporal_correlation_prefetcher
	import tcp_pkg::*;
#(
	parameter int TRAIN_ENTRIES     = 256,
	parameter int CORR_ENTRIES      = 4096,
	parameter int BLOCK_OFFSET_BITS = 6,
	parameter int MAX_DEGREE        = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration write channel
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [DEGREE_W-1:0] prefetch_degree,
	// access channel
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                req_type,
	input  wire logic [ADDR_W-1:0]   pc,
	input  wire logic [ADDR_W-1:0]   byte_address,
	// prefetch channel
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic      [ADDR_W-1:0]   prefetch_address,
	output logic                     last_of_run
);

	// table geometry; entry counts are taken as powers of two (index is the low bits)
	localparam int BLK_W   = ADDR_W - BLOCK_OFFSET_BITS;
	localparam int TIDX_W  = (TRAIN_ENTRIES > 1) ? $clog2(TRAIN_ENTRIES) : 1;
	localparam int CIDX_W  = $clog2(CORR_ENTRIES);
	localparam int CLR_N   = (TRAIN_ENTRIES > CORR_ENTRIES) ? TRAIN_ENTRIES : CORR_ENTRIES;
	localparam int CLR_W   = $clog2(CLR_N);
	localparam int CNT_W   = $clog2(MAX_DEGREE + 1);
	localparam int TRAIN_W = 1 + ADDR_W + BLK_W;
	localparam int CORR_W  = 1 + BLK_W + BLK_W;

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_TCHK,
		S_LOOK,
		S_CHK,
		S_FIN
	} state_t;

	state_t             state_q;
	logic [CLR_W-1:0]   clr_q;
	logic [DEGREE_W-1:0] degree_q;
	logic [ADDR_W-1:0]  pc_q;
	logic [BLK_W-1:0]   blk_q;
	logic [TIDX_W-1:0]  tidx_q;
	logic [BLK_W-1:0]   cur_q;      // block being looked up, also the pending prefetch
	logic [CNT_W-1:0]   cnt_q;      // prefetches found so far for this load
	logic               out_valid_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic               out_last_q;

	// training table ports
	logic               t_we, t_re;
	logic [TIDX_W-1:0]  t_waddr, t_raddr;
	logic [TRAIN_W-1:0] t_wdata, t_rdata;
	// correlation table ports
	logic               c_we, c_re;
	logic [CIDX_W-1:0]  c_waddr, c_raddr;
	logic [CORR_W-1:0]  c_wdata, c_rdata;

	// read word fields
	logic               t_rd_valid;
	logic [ADDR_W-1:0]  t_rd_key;
	logic [BLK_W-1:0]   t_rd_last;
	logic               c_rd_valid;
	logic [BLK_W-1:0]   c_rd_key;
	logic [BLK_W-1:0]   c_rd_next;

	// shared comparator operands
	logic               m_valid;
	logic [ADDR_W-1:0]  m_probe, m_key, m_data, m_succ;
	tcp_match_t         m_flags;

	logic [BLK_W-1:0]   in_blk;
	logic [TIDX_W-1:0]  in_tidx;
	logic [CNT_W-1:0]   limit;
	logic               slot_free;
	logic               out_load;
	logic               accept;
	logic               clr_train;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;

	// a prefetch enters the output register from the chain walk or the final step
	assign out_load = slot_free &&
		(((state_q == S_CHK) && (cnt_q != '0)) || (state_q == S_FIN));

	assign out_valid        = out_valid_q;
	assign prefetch_address = out_addr_q;
	assign last_of_run      = out_last_q;

	assign in_blk  = byte_address[ADDR_W-1:BLOCK_OFFSET_BITS];
	assign in_tidx = (TRAIN_ENTRIES > 1) ? pc[TIDX_W-1:0] : '0;

	// degree above the hardware maximum is clipped
	assign limit = (8'(degree_q) > 8'(MAX_DEGREE)) ? CNT_W'(MAX_DEGREE) : CNT_W'(degree_q);

	assign {t_rd_valid, t_rd_key, t_rd_last} = t_rdata;
	assign {c_rd_valid, c_rd_key, c_rd_next} = c_rdata;

	assign clr_train = ({1'b0, clr_q} < (CLR_W + 1)'(TRAIN_ENTRIES));

	// one comparator: pc key while training, block key while walking the chain
	always_comb begin
		if (state_q == S_TCHK) begin
			m_valid = t_rd_valid;
			m_probe = pc_q;
			m_key   = t_rd_key;
			m_data  = ADDR_W'(t_rd_last);
		end else begin
			m_valid = c_rd_valid;
			m_probe = ADDR_W'(cur_q);
			m_key   = ADDR_W'(c_rd_key);
			m_data  = ADDR_W'(c_rd_next);
		end
	end

	tcp_match u_match (
		.valid (m_valid),
		.probe (m_probe),
		.key   (m_key),
		.data  (m_data),
		.flags (m_flags),
		.succ  (m_succ)
	);

	// table port control
	always_comb begin
		t_re    = accept && (req_type == 1'b0);
		t_raddr = in_tidx;
		t_we    = 1'b0;
		t_waddr = tidx_q;
		t_wdata = {1'b1, pc_q, blk_q};
		c_re    = (state_q == S_LOOK);
		c_raddr = cur_q[CIDX_W-1:0];
		c_we    = 1'b0;
		c_waddr = t_rd_last[CIDX_W-1:0];
		c_wdata = {1'b1, t_rd_last, blk_q};
		unique case (state_q)
			S_CLR: begin
				// sweep clears the valid bit of every entry
				t_we    = clr_train;
				t_waddr = clr_q[TIDX_W-1:0];
				t_wdata = '0;
				c_we    = 1'b1;
				c_waddr = clr_q[CIDX_W-1:0];
				c_wdata = '0;
			end
			S_TCHK: begin
				// on a pc hit record last block -> current block, and refresh the pc entry
				t_we = 1'b1;
				c_we = m_flags.hit;
			end
			default: begin
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= DEGREE_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			degree_q <= prefetch_degree;
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (slot_free) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_W'(CLR_N - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					// other accesses are dropped in the transfer cycle
					if (accept && (req_type == 1'b0)) begin
						pc_q    <= pc;
						blk_q   <= in_blk;
						tidx_q  <= in_tidx;
						state_q <= S_TCHK;
					end
				end
				S_TCHK: begin
					cur_q <= blk_q;
					cnt_q <= '0;
					if (limit == '0) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					// a pending prefetch leaves once its successor is known
					if ((cnt_q == '0) || slot_free) begin
						if (cnt_q != '0) begin
							out_addr_q  <= {cur_q, BLOCK_OFFSET_BITS'(0)};
							out_last_q  <= !m_flags.succ_nz;
						end
						if (!m_flags.succ_nz) begin
							state_q <= S_IDLE;
						end else begin
							cur_q <= m_succ[BLK_W-1:0];
							cnt_q <= cnt_q + 1'b1;
							if (cnt_q + 1'b1 == limit) begin
								state_q <= S_FIN;
							end else begin
								state_q <= S_LOOK;
							end
						end
					end
				end
				S_FIN: begin
					// degree used up: final prefetch closes the run
					if (slot_free) begin
						out_addr_q  <= {cur_q, BLOCK_OFFSET_BITS'(0)};
						out_last_q  <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	tcp_ram #(
		.DEPTH (TRAIN_ENTRIES),
		.WIDTH (TRAIN_W),
		.AW    (TIDX_W)
	) u_train (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.re    (t_re),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	tcp_ram #(
		.DEPTH (CORR_ENTRIES),
		.WIDTH (CORR_W),
		.AW    (CIDX_W)
	) u_corr (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.re    (c_re),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

endmodule

`default_nettype wire

@@ rtl/core/tcp_checker.sv @@
// ----------------------------------------------------------------------------
// tcp_checker
// port-level checks of the prefetcher, attached by bind
// ----------------------------------------------------------------------------
`default_nettype none

`include "temporal_correlation_prefetcher_defines.svh"

module tcp_checker
	import tcp_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic              req_type,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [ADDR_W-1:0] prefetch_address,
	input wire logic              last_of_run
);

	// a load transfer makes the block busy on the next cycle
	`TCP_ASSERT_NEXT(a_load_busy, in_valid && !in_stall && !req_type, in_stall)

	// an ignored access leaves the block free to take the next one
	`TCP_ASSERT_NEXT(a_other_free, in_valid && !in_stall && req_type, !in_stall)

	// a stalled prefetch holds
	`TCP_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(prefetch_address) && $stable(last_of_run))

endmodule

bind temporal_correlation_prefetcher tcp_checker u_tcp_checker (.*);

`default_nettype wire
